[hw/rtl/prs_pkg.sv]
// shared types and constants for the peer resync scheduler
// no dependencies; imported by every module of the block
`default_nettype none

package prs_pkg;

  // event codes
  localparam logic [1:0] OP_GOSSIP = 2'd0;
  localparam logic [1:0] OP_REPORT = 2'd1;
  localparam logic [1:0] OP_REPLY  = 2'd2;
  localparam logic [1:0] OP_TICK   = 2'd3;

  // request kinds
  localparam logic KIND_REPAIR = 1'b0;
  localparam logic KIND_PROBE  = 1'b1;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_RETRY = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PROBE = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CLEAR = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MESH  = 8'd3;

  // register reset values
  localparam logic [15:0] RETRY_RST = 16'd8;
  localparam logic [15:0] PROBE_RST = 16'd100;
  localparam logic [3:0]  CLEAR_RST = 4'd8;
  localparam logic [31:0] MESH_RST  = 32'd1;

  localparam logic [3:0] STREAK_MAX = 4'hf;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] peer_id;
    logic        behind;
  } in_item_t;

  typedef struct packed {
    logic [31:0] request_peer;
    logic        request_kind;
    logic        last;
  } out_item_t;

  // one table entry as kept in the entry memory
  typedef struct packed {
    logic [31:0] peer;
    logic        need_repair;
    logic        awaiting;
    logic [31:0] heard_stamp;
    logic [31:0] request_stamp;
    logic [3:0]  streak;
  } entry_t;

  // request hand-off from the sequencer to the output stage
  typedef struct packed {
    logic        push;
    logic        flush;
    logic [31:0] peer;
    logic        kind;
  } out_ctl_t;

endpackage

`default_nettype wire

[hw/rtl/peer_resync_scheduler.sv]
// peer resync scheduler top level: event sequencer, config registers, valid bits
// depends on prs_pkg, prs_entry_mem and prs_out_stage
`default_nettype none

// usage
//   input channel: an event request is taken at a rising edge with start high
//   and busy low; in_item carries opcode, peer_id and behind.
//   result channel: each index request sits on out_item for one cycle, marked
//   by out_strobe; the receiver cannot stall, so requests are never held off.
//   out_item.last marks the final request of a tick.
//   config channel: cfg_valid/cfg_ready write cfg_data to register cfg_index
//   (0 retry_ticks, 1 probe_ticks, 2 clear_streak, 3 mesh_peer_id); other
//   indexes are ignored. cfg_ready is always high; write only while idle.
// timing
//   a lookup event reads the entry memory at most once per entry, stopping at
//   a hit and reading every entry on a miss or when the table is full; an
//   event with a zero key returns at once.
//   a tick reads each entry in turn and rewrites those that send a request;
//   the reads pause for every entry that sends both a repair and a probe.
//   the walk covers one entry per cycle while no second request is owed.
//   the last request of a tick leaves through ST_FLUSH and the output stage.
// reset
//   synchronous active-low reset clears all valid bits, the tick counter and
//   loads the register defaults; the memory itself is never cleared.

module peer_resync_scheduler #(
  parameter int unsigned MAX_PEERS = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // event requests
  input  wire logic                          start,
  output logic                               busy,
  input  wire prs_pkg::in_item_t             in_item,
  // index requests
  output logic                               out_strobe,
  output prs_pkg::out_item_t                 out_item,
  // configuration writes
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [prs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]                   cfg_data
);
  import prs_pkg::*;

  localparam int unsigned IDX_W = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_PEERS + 1);
  localparam logic [CNT_W-1:0] CNT_END = CNT_W'(MAX_PEERS);

  // sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_LOOK  = 3'd1;  // scan for the key, note first free entry
  localparam logic [2:0] ST_MOD   = 3'd2;  // apply the event, write back
  localparam logic [2:0] ST_WALK  = 3'd3;  // tick walk over all entries
  localparam logic [2:0] ST_FLUSH = 3'd4;  // release last request, bump tick

  // event update of one entry
  function automatic entry_t apply_event(entry_t base, logic [1:0] op, logic behind,
                                         logic [31:0] tick, logic [3:0] clear);
    entry_t     e;
    logic [3:0] s;
    e = base;
    s = (base.streak == STREAK_MAX) ? base.streak : base.streak + 4'd1;
    case (op)
      OP_GOSSIP: begin
        e.heard_stamp = tick;
        e.need_repair = behind;
      end
      OP_REPORT: begin
        e.heard_stamp = tick;
        if (behind) begin
          e.need_repair = 1'b1;
          e.streak      = 4'd0;
        end else if (!base.awaiting) begin
          e.streak = s;
          if (s >= clear) begin
            e.need_repair = 1'b0;
          end
        end
      end
      OP_REPLY: begin
        e.awaiting = 1'b0;
      end
      default: begin
        e = base;
      end
    endcase
    return e;
  endfunction

  // configuration registers
  logic [15:0] retry_r;
  logic [15:0] probe_r;
  logic [3:0]  clear_r;
  logic [31:0] mesh_r;

  // sequencer state
  logic [2:0]           state_r, state_nxt;
  logic [1:0]           op_r, op_nxt;
  logic                 behind_r, behind_nxt;
  logic [31:0]          key_r, key_nxt;
  logic [CNT_W-1:0]     rd_idx_r, rd_idx_nxt;
  logic                 cmp_v_r, cmp_v_nxt;
  logic [IDX_W-1:0]     cmp_idx_r, cmp_idx_nxt;
  logic                 free_v_r, free_v_nxt;
  logic [IDX_W-1:0]     free_idx_r, free_idx_nxt;
  logic [IDX_W-1:0]     mod_idx_r, mod_idx_nxt;
  entry_t               base_r, base_nxt;
  logic                 second_r, second_nxt;
  logic [31:0]          tick_r, tick_nxt;
  logic [MAX_PEERS-1:0] valid_r, valid_nxt;

  // memory port signals
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  entry_t           mem_wdata;
  logic             mem_re;
  logic [IDX_W-1:0] mem_raddr;
  entry_t           mem_rdata;

  out_ctl_t out_ctl;

  // tick walk evaluation of the entry under compare
  logic   ent_valid;
  logic   rep_fire;
  logic   prb_fire;
  logic   both_fire;
  entry_t walk_upd;
  logic   key_hit;
  logic   accept;
  logic [31:0] ev_key;

  assign accept    = start && !busy;
  assign ent_valid = valid_r[cmp_idx_r];
  assign rep_fire  = mem_rdata.need_repair &&
                     (!mem_rdata.awaiting ||
                      ((tick_r - mem_rdata.request_stamp) >= {16'd0, retry_r}));
  assign prb_fire  = (tick_r - mem_rdata.heard_stamp) >= {16'd0, probe_r};
  assign both_fire = rep_fire && prb_fire;
  assign key_hit   = cmp_v_r && ent_valid && (mem_rdata.peer == key_r);
  // gossip keys on its source, reports and replies on the mesh entry
  assign ev_key    = (in_item.opcode == OP_GOSSIP) ? in_item.peer_id : mesh_r;

  always_comb begin
    walk_upd = mem_rdata;
    if (rep_fire) begin
      walk_upd.awaiting      = 1'b1;
      walk_upd.request_stamp = tick_r;
    end
    if (prb_fire) begin
      walk_upd.awaiting    = 1'b1;
      walk_upd.heard_stamp = tick_r;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    op_nxt       = op_r;
    behind_nxt   = behind_r;
    key_nxt      = key_r;
    rd_idx_nxt   = rd_idx_r;
    cmp_v_nxt    = cmp_v_r;
    cmp_idx_nxt  = cmp_idx_r;
    free_v_nxt   = free_v_r;
    free_idx_nxt = free_idx_r;
    mod_idx_nxt  = mod_idx_r;
    base_nxt     = base_r;
    second_nxt   = second_r;
    tick_nxt     = tick_r;
    valid_nxt    = valid_r;
    mem_we       = 1'b0;
    mem_waddr    = mod_idx_r;
    mem_wdata    = apply_event(base_r, op_r, behind_r, tick_r, clear_r);
    mem_re       = 1'b0;
    mem_raddr    = rd_idx_r[IDX_W-1:0];
    out_ctl      = '{push: 1'b0, flush: 1'b0, peer: mem_rdata.peer, kind: KIND_REPAIR};

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          op_nxt     = in_item.opcode;
          behind_nxt = in_item.behind;
          key_nxt    = ev_key;
          rd_idx_nxt = '0;
          cmp_v_nxt  = 1'b0;
          free_v_nxt = 1'b0;
          second_nxt = 1'b0;
          if (in_item.opcode == OP_TICK) begin
            state_nxt = ST_WALK;
          end else if (ev_key != 32'd0) begin
            state_nxt = ST_LOOK;
          end
        end
      end

      ST_LOOK: begin
        if (key_hit) begin
          base_nxt    = mem_rdata;
          mod_idx_nxt = cmp_idx_r;
          state_nxt   = ST_MOD;
        end else begin
          // lowest free entry is the first invalid one passed in index order
          if (cmp_v_r && !ent_valid && !free_v_r) begin
            free_v_nxt   = 1'b1;
            free_idx_nxt = cmp_idx_r;
          end
          if (rd_idx_r != CNT_END) begin
            mem_re      = 1'b1;
            cmp_v_nxt   = 1'b1;
            cmp_idx_nxt = rd_idx_r[IDX_W-1:0];
            rd_idx_nxt  = rd_idx_r + 1'b1;
          end else begin
            cmp_v_nxt = 1'b0;
          end
          if (!cmp_v_r && (rd_idx_r == CNT_END)) begin
            if (free_v_r) begin
              // fresh entry for an unknown peer
              base_nxt = '{peer: key_r, need_repair: 1'b0, awaiting: 1'b0,
                           heard_stamp: tick_r, request_stamp: 32'd0, streak: 4'd0};
              mod_idx_nxt = free_idx_r;
              state_nxt   = ST_MOD;
            end else begin
              // table full: drop the event
              state_nxt = ST_IDLE;
            end
          end
        end
      end

      ST_MOD: begin
        mem_we                 = 1'b1;
        valid_nxt[mod_idx_r]   = 1'b1;
        state_nxt              = ST_IDLE;
      end

      ST_WALK: begin
        if (second_r) begin
          // probe of an entry that also sent a repair last cycle
          out_ctl.push = 1'b1;
          out_ctl.kind = KIND_PROBE;
          second_nxt   = 1'b0;
        end else if (cmp_v_r && ent_valid && (rep_fire || prb_fire)) begin
          mem_we       = 1'b1;
          mem_waddr    = cmp_idx_r;
          mem_wdata    = walk_upd;
          out_ctl.push = 1'b1;
          out_ctl.kind = rep_fire ? KIND_REPAIR : KIND_PROBE;
          second_nxt   = both_fire;
        end
        // hold the read stream while a second request is owed
        if (!(cmp_v_r && !second_r && ent_valid && both_fire)) begin
          if (rd_idx_r != CNT_END) begin
            mem_re      = 1'b1;
            cmp_v_nxt   = 1'b1;
            cmp_idx_nxt = rd_idx_r[IDX_W-1:0];
            rd_idx_nxt  = rd_idx_r + 1'b1;
          end else begin
            cmp_v_nxt = 1'b0;
          end
        end
        if (!cmp_v_r && !second_r && (rd_idx_r == CNT_END)) begin
          state_nxt = ST_FLUSH;
        end
      end

      ST_FLUSH: begin
        out_ctl.flush = 1'b1;
        tick_nxt      = tick_r + 32'd1;
        state_nxt     = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      cmp_v_r  <= 1'b0;
      free_v_r <= 1'b0;
      second_r <= 1'b0;
      tick_r   <= 32'd0;
      valid_r  <= '0;
      rd_idx_r <= '0;
    end else begin
      state_r  <= state_nxt;
      cmp_v_r  <= cmp_v_nxt;
      free_v_r <= free_v_nxt;
      second_r <= second_nxt;
      tick_r   <= tick_nxt;
      valid_r  <= valid_nxt;
      rd_idx_r <= rd_idx_nxt;
    end
  end

  // event payload
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    behind_r   <= behind_nxt;
    key_r      <= key_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    free_idx_r <= free_idx_nxt;
    mod_idx_r  <= mod_idx_nxt;
    base_r     <= base_nxt;
  end

  // configuration registers, unknown indexes fall through
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      retry_r <= RETRY_RST;
      probe_r <= PROBE_RST;
      clear_r <= CLEAR_RST;
      mesh_r  <= MESH_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_RETRY: retry_r <= cfg_data[15:0];
        CFG_PROBE: probe_r <= cfg_data[15:0];
        CFG_CLEAR: clear_r <= cfg_data[3:0];
        CFG_MESH:  mesh_r  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign cfg_ready = 1'b1;
  assign busy      = (state_r != ST_IDLE);

  prs_entry_mem #(
    .DEPTH (MAX_PEERS),
    .IDX_W (IDX_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  prs_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (out_ctl),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

  // the last request of a tick is never followed directly by another
  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_item.last |=> !out_strobe)
    else $error("request right after last");

  // the entry memory is only written by an event update or the tick walk
  a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == ST_MOD) || (state_r == ST_WALK))
    else $error("memory write outside update");

  // an accepted tick always starts a walk
  a_tick_walk: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_item.opcode == OP_TICK) |=> (state_r == ST_WALK))
    else $error("tick did not start walk");

  // a owed probe only exists during the walk
  a_second_walk: assert property (@(posedge clk) disable iff (!rst_n)
    second_r |-> (state_r == ST_WALK))
    else $error("pending probe outside walk");

endmodule

`default_nettype wire

[hw/rtl/prs_entry_mem.sv]
// peer entry memory: one write port, one read port, registered read data
// depends on prs_pkg for the entry type
`default_nettype none

module prs_entry_mem #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned IDX_W = 5
) (
  input  wire logic                   clk,
  input  wire logic                   we,
  input  wire logic [IDX_W-1:0]       waddr,
  input  wire prs_pkg::entry_t        wdata,
  input  wire logic                   re,
  input  wire logic [IDX_W-1:0]       raddr,
  output prs_pkg::entry_t             rdata
);
  import prs_pkg::*;

  entry_t mem_r [DEPTH];
  entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

[hw/rtl/prs_out_stage.sv]
// result stage: holds one request back so the final one of a tick gets last
// depends on prs_pkg for the hand-off and result types
`default_nettype none

module prs_out_stage (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire prs_pkg::out_ctl_t ctl,
  output logic                   out_strobe,
  output prs_pkg::out_item_t     out_item
);
  import prs_pkg::*;

  logic        pend_v_r, pend_v_nxt;
  logic [31:0] pend_peer_r, pend_peer_nxt;
  logic        pend_kind_r, pend_kind_nxt;
  logic        strobe_r, strobe_nxt;
  out_item_t   item_r, item_nxt;

  always_comb begin
    pend_v_nxt    = pend_v_r;
    pend_peer_nxt = pend_peer_r;
    pend_kind_nxt = pend_kind_r;
    strobe_nxt    = 1'b0;
    item_nxt      = item_r;
    if (ctl.push) begin
      if (pend_v_r) begin
        strobe_nxt = 1'b1;
        item_nxt   = '{request_peer: pend_peer_r, request_kind: pend_kind_r, last: 1'b0};
      end
      pend_v_nxt    = 1'b1;
      pend_peer_nxt = ctl.peer;
      pend_kind_nxt = ctl.kind;
    end else if (ctl.flush && pend_v_r) begin
      strobe_nxt = 1'b1;
      item_nxt   = '{request_peer: pend_peer_r, request_kind: pend_kind_r, last: 1'b1};
      pend_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      pend_v_r <= pend_v_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_peer_r <= pend_peer_nxt;
    pend_kind_r <= pend_kind_nxt;
    item_r      <= item_nxt;
  end

  assign out_strobe = strobe_r;
  assign out_item   = item_r;

endmodule

`default_nettype wire
